### sv/tbme_pkg.sv
// ----------------------------------------------------------------------------
// tbme_pkg
// Shared types and codes for the two-base modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbme_pkg;

  localparam int DATA_W    = 64;
  localparam int WIDTH_DEF = 64;
  localparam int IN_W      = 4 * DATA_W;

  localparam int SEL_W = 3;
  localparam int DST_W = 2;

  // multiplier operand sources
  localparam logic [SEL_W-1:0] SRC_ONE   = 3'd0;
  localparam logic [SEL_W-1:0] SRC_BASE1 = 3'd1;
  localparam logic [SEL_W-1:0] SRC_BASE2 = 3'd2;
  localparam logic [SEL_W-1:0] SRC_LONE  = 3'd3;
  localparam logic [SEL_W-1:0] SRC_PROD  = 3'd4;
  localparam logic [SEL_W-1:0] SRC_ACC   = 3'd5;
  localparam logic [SEL_W-1:0] SRC_P1    = 3'd6;

  // multiplier result destinations
  localparam logic [DST_W-1:0] DST_BASE1 = 2'd0;
  localparam logic [DST_W-1:0] DST_BASE2 = 2'd1;
  localparam logic [DST_W-1:0] DST_PROD  = 2'd2;
  localparam logic [DST_W-1:0] DST_ACC   = 2'd3;

  typedef struct packed {
    logic             load;
    logic             mul_start;
    logic [SEL_W-1:0] src_x;
    logic [SEL_W-1:0] src_y;
    logic [DST_W-1:0] dst;
    logic             exp_first;
    logic             exp_second;
    logic             exp_shift;
    logic             acc_init;
    logic             p1_save;
    logic             out_load;
    logic             out_zero;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic m_zero;
    logic exp_bit;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### sv/tbme_mulmod.sv
// ----------------------------------------------------------------------------
// tbme_mulmod
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbme_mulmod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tbme_pkg::DATA_W-1:0] x,
  input  logic [tbme_pkg::DATA_W-1:0] y,
  input  logic [tbme_pkg::DATA_W-1:0] m,
  output logic                        done,
  output logic [tbme_pkg::DATA_W-1:0] p
);

  localparam int DW    = tbme_pkg::DATA_W;
  localparam int BIT_W = $clog2(DW);

  logic             busy;
  logic [BIT_W-1:0] cnt;
  logic [DW-1:0]    xr;
  logic [DW-1:0]    yr;
  logic [DW-1:0]    acc;
  logic [DW:0]      dbl;
  logic [DW:0]      dbl_red;
  logic [DW:0]      sum;
  logic [DW:0]      sum_red;
  logic [DW:0]      m_ext;

  assign m_ext   = {1'b0, m};
  assign dbl     = {acc, 1'b0};
  assign dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
  assign sum     = dbl_red + (yr[DW-1] ? {1'b0, xr} : '0);
  assign sum_red = (sum >= m_ext) ? sum - m_ext : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= x;
      yr  <= y;
      acc <= '0;
      cnt <= BIT_W'(DW - 1);
    end else if (busy) begin
      acc <= sum_red[DW-1:0];
      yr  <= yr << 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign p = acc;

endmodule

`default_nettype wire

### sv/tbme_datapath.sv
// ----------------------------------------------------------------------------
// tbme_datapath
// Operand registers, exponent scan register, modulus, output register and
// the shared modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tbme_datapath #(
  parameter int WIDTH = tbme_pkg::WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tbme_pkg::DATA_W-1:0] cfg_wr_data,
  input  logic [tbme_pkg::IN_W-1:0]   s_tdata,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [tbme_pkg::DATA_W-1:0] m_tdata,
  input  tbme_pkg::cmd_t              cmd,
  output tbme_pkg::sts_t              sts
);

  localparam int DW = tbme_pkg::DATA_W;
  localparam logic [DW-1:0] OP_MASK = {DW{1'b1}} >> (DW - WIDTH);

  logic [DW-1:0]    modulus;
  logic [DW-1:0]    base1;
  logic [DW-1:0]    base2;
  logic [DW-1:0]    prod;
  logic [DW-1:0]    acc;
  logic [DW-1:0]    p1;
  logic [DW-1:0]    one;
  logic [DW-1:0]    lone;
  logic [DW-1:0]    op_x;
  logic [DW-1:0]    op_y;
  logic [DW-1:0]    mul_p;
  logic             mul_done;
  logic [WIDTH-1:0] exp1;
  logic [WIDTH-1:0] exp2;
  logic [WIDTH-1:0] diff_exp;
  logic [WIDTH-1:0] ebits;
  logic             e_ge;
  logic             lone_sel;
  logic [tbme_pkg::DST_W-1:0] dst_lat;
  logic             out_valid;
  logic [DW-1:0]    out_data;

  function automatic logic [DW-1:0] pick(
    input logic [tbme_pkg::SEL_W-1:0] sel,
    input logic [DW-1:0] v_one,
    input logic [DW-1:0] v_b1,
    input logic [DW-1:0] v_b2,
    input logic [DW-1:0] v_lone,
    input logic [DW-1:0] v_prod,
    input logic [DW-1:0] v_acc,
    input logic [DW-1:0] v_p1
  );
    logic [DW-1:0] v;
    unique case (sel)
      tbme_pkg::SRC_ONE:   v = v_one;
      tbme_pkg::SRC_BASE1: v = v_b1;
      tbme_pkg::SRC_BASE2: v = v_b2;
      tbme_pkg::SRC_LONE:  v = v_lone;
      tbme_pkg::SRC_PROD:  v = v_prod;
      tbme_pkg::SRC_ACC:   v = v_acc;
      tbme_pkg::SRC_P1:    v = v_p1;
      default:             v = '0;
    endcase
    return v;
  endfunction

  assign one  = (modulus == DW'(1)) ? '0 : DW'(1);
  assign lone = lone_sel ? base2 : base1;
  assign e_ge = (exp1 >= exp2);
  assign op_x = pick(cmd.src_x, one, base1, base2, lone, prod, acc, p1);
  assign op_y = pick(cmd.src_y, one, base1, base2, lone, prod, acc, p1);

  tbme_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .x     (op_x),
    .y     (op_y),
    .m     (modulus),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= DW'(1);
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base1 <= s_tdata[0 +: DW] & OP_MASK;
      exp1  <= s_tdata[DW +: WIDTH];
      base2 <= s_tdata[2*DW +: DW] & OP_MASK;
      exp2  <= s_tdata[3*DW +: WIDTH];
    end
    if (cmd.mul_start) begin
      dst_lat <= cmd.dst;
    end
    if (mul_done) begin
      unique case (dst_lat)
        tbme_pkg::DST_BASE1: base1 <= mul_p;
        tbme_pkg::DST_BASE2: base2 <= mul_p;
        tbme_pkg::DST_PROD:  prod  <= mul_p;
        tbme_pkg::DST_ACC:   acc   <= mul_p;
      endcase
    end
    if (cmd.acc_init) begin
      acc <= one;
    end
    if (cmd.p1_save) begin
      p1 <= acc;
    end
    if (cmd.exp_first) begin
      lone_sel <= !e_ge;
      diff_exp <= e_ge ? exp1 - exp2 : exp2 - exp1;
      ebits    <= e_ge ? exp2 : exp1;
    end else if (cmd.exp_second) begin
      ebits <= diff_exp;
    end else if (cmd.exp_shift) begin
      ebits <= ebits << 1;
    end
    if (cmd.out_load) begin
      out_data <= cmd.out_zero ? '0 : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign sts.mul_done = mul_done;
  assign sts.m_zero   = (modulus == '0);
  assign sts.exp_bit  = ebits[WIDTH-1];
  assign sts.out_free = !out_valid || m_tready;

endmodule

`default_nettype wire

### sv/tbme_ctrl.sv
// ----------------------------------------------------------------------------
// tbme_ctrl
// Sequencer: operand reduction, base product, two square-and-multiply
// passes, final product and output handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module tbme_ctrl #(
  parameter int WIDTH = tbme_pkg::WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  tbme_pkg::sts_t sts,
  output tbme_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(WIDTH);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RED1  = 5'd1;
  localparam logic [4:0] S_RED1W = 5'd2;
  localparam logic [4:0] S_RED2  = 5'd3;
  localparam logic [4:0] S_RED2W = 5'd4;
  localparam logic [4:0] S_PROD  = 5'd5;
  localparam logic [4:0] S_PRODW = 5'd6;
  localparam logic [4:0] S_SEL   = 5'd7;
  localparam logic [4:0] S_SQ    = 5'd8;
  localparam logic [4:0] S_SQW   = 5'd9;
  localparam logic [4:0] S_MU    = 5'd10;
  localparam logic [4:0] S_MUW   = 5'd11;
  localparam logic [4:0] S_NEXT  = 5'd12;
  localparam logic [4:0] S_SEL2  = 5'd13;
  localparam logic [4:0] S_FIN   = 5'd14;
  localparam logic [4:0] S_FINW  = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [4:0]       state;
  logic [4:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             phase;
  logic             phase_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = sts.m_zero ? S_OUT : S_RED1;
        end
      end
      S_RED1: begin
        cmd.mul_start = 1'b1;
        cmd.src_x     = tbme_pkg::SRC_ONE;
        cmd.src_y     = tbme_pkg::SRC_BASE1;
        cmd.dst       = tbme_pkg::DST_BASE1;
        state_next    = S_RED1W;
      end
      S_RED1W: begin
        if (sts.mul_done) state_next = S_RED2;
      end
      S_RED2: begin
        cmd.mul_start = 1'b1;
        cmd.src_x     = tbme_pkg::SRC_ONE;
        cmd.src_y     = tbme_pkg::SRC_BASE2;
        cmd.dst       = tbme_pkg::DST_BASE2;
        state_next    = S_RED2W;
      end
      S_RED2W: begin
        if (sts.mul_done) state_next = S_PROD;
      end
      S_PROD: begin
        cmd.mul_start = 1'b1;
        cmd.src_x     = tbme_pkg::SRC_BASE1;
        cmd.src_y     = tbme_pkg::SRC_BASE2;
        cmd.dst       = tbme_pkg::DST_PROD;
        state_next    = S_PRODW;
      end
      S_PRODW: begin
        if (sts.mul_done) state_next = S_SEL;
      end
      S_SEL: begin
        cmd.exp_first = 1'b1;
        cmd.acc_init  = 1'b1;
        cnt_next      = CNT_W'(WIDTH - 1);
        phase_next    = 1'b0;
        state_next    = S_SQ;
      end
      S_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.src_x     = tbme_pkg::SRC_ACC;
        cmd.src_y     = tbme_pkg::SRC_ACC;
        cmd.dst       = tbme_pkg::DST_ACC;
        state_next    = S_SQW;
      end
      S_SQW: begin
        if (sts.mul_done) state_next = sts.exp_bit ? S_MU : S_NEXT;
      end
      S_MU: begin
        cmd.mul_start = 1'b1;
        cmd.src_x     = tbme_pkg::SRC_ACC;
        cmd.src_y     = phase ? tbme_pkg::SRC_LONE : tbme_pkg::SRC_PROD;
        cmd.dst       = tbme_pkg::DST_ACC;
        state_next    = S_MUW;
      end
      S_MUW: begin
        if (sts.mul_done) state_next = S_NEXT;
      end
      S_NEXT: begin
        cmd.exp_shift = 1'b1;
        if (cnt == '0) begin
          state_next = phase ? S_FIN : S_SEL2;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = S_SQ;
        end
      end
      S_SEL2: begin
        cmd.p1_save    = 1'b1;
        cmd.acc_init   = 1'b1;
        cmd.exp_second = 1'b1;
        cnt_next       = CNT_W'(WIDTH - 1);
        phase_next     = 1'b1;
        state_next     = S_SQ;
      end
      S_FIN: begin
        cmd.mul_start = 1'b1;
        cmd.src_x     = tbme_pkg::SRC_P1;
        cmd.src_y     = tbme_pkg::SRC_ACC;
        cmd.dst       = tbme_pkg::DST_ACC;
        state_next    = S_FINW;
      end
      S_FINW: begin
        if (sts.mul_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = sts.m_zero;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

### sv/two_base_modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// two_base_modular_exponentiation_top
// base_first^exp_first * base_second^exp_second mod modulus, shared-power
// square-and-multiply on one bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One request at a time. Every modular multiplication runs on a single
// bit-serial interleaved multiplier. A request costs 2 reductions, 1 base
// product, 2*WIDTH squarings, one multiply per set bit of the shared and
// difference exponents, and 1 final product: between 2*WIDTH+4 and
// 4*WIDTH+4 multiplications, plus control steps per exponent bit. A zero
// modulus skips the multiplications and returns 0. The next request is
// taken as soon as the previous result is in the output register, even if
// it is not yet read.
`default_nettype none

module two_base_modular_exponentiation_top #(
  parameter int WIDTH = tbme_pkg::WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tbme_pkg::DATA_W-1:0] cfg_wr_data,   // modulus
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // base_first, exp_first, base_second, exp_second
  input  logic [tbme_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tbme_pkg::DATA_W-1:0] m_axis_tdata   // result
);

  tbme_pkg::cmd_t cmd;
  tbme_pkg::sts_t sts;

  tbme_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbme_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_axis_tdata),
    .m_tready    (m_axis_tready),
    .m_tvalid    (m_axis_tvalid),
    .m_tdata     (m_axis_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

### sv/tbme_checker.sv
// ----------------------------------------------------------------------------
// tbme_checker
// Port-level checks for the two-base modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

module tbme_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_wr_en,
  input logic [tbme_pkg::DATA_W-1:0] cfg_wr_data,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [tbme_pkg::DATA_W-1:0] m_axis_tdata
);

  logic [tbme_pkg::DATA_W-1:0] mod_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_seen <= tbme_pkg::DATA_W'(1);
    end else if (cfg_wr_en) begin
      mod_seen <= cfg_wr_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((mod_seen == '0) ? (m_axis_tdata == '0)
                                        : (m_axis_tdata < mod_seen)))
    else $error("result not reduced");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without request in flight");

endmodule

bind two_base_modular_exponentiation_top tbme_checker u_tbme_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_wr_en     (cfg_wr_en),
  .cfg_wr_data   (cfg_wr_data),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### dv/two_base_modular_exponentiation_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_base_modular_exponentiation_top_tb
// Self-checking bench for the two-base modular exponentiation block. Requests
// are queued by a sequencer, sent by a clocked driver under random idling and
// checked in order against a behavioral model of
// base_first^exp_first * base_second^exp_second mod modulus. It sweeps
// several modulus settings, the zero modulus among them.
// ----------------------------------------------------------------------------

module two_base_modular_exponentiation_top_tb;

  localparam int OP_W        = tbme_pkg::WIDTH_DEF;
  localparam int STALL_LIMIT = 100000;

  typedef struct {
    logic [tbme_pkg::IN_W-1:0] data;
    logic                      hold;
  } request_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [tbme_pkg::DATA_W-1:0]   cfg_wr_data = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // base_first, exp_first, base_second, exp_second
  logic [tbme_pkg::IN_W-1:0]     s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // result
  logic [tbme_pkg::DATA_W-1:0]   m_axis_tdata;

  request_t                      request_q[$];
  logic [tbme_pkg::DATA_W-1:0]   product_q[$];
  logic [tbme_pkg::DATA_W-1:0]   modulus_shadow = 64'd1;
  logic                          in_fire = 1'b0;
  int                            src_idle_pct = 0;
  int                            snk_idle_pct = 0;
  int                            fail_cnt = 0;
  int                            stall_cycles = 0;

  always #2 clk = ~clk;

  two_base_modular_exponentiation_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [127:0] p;
    p = ({64'd0, x} * {64'd0, y}) % {64'd0, m};
    return p[63:0];
  endfunction

  function automatic logic [63:0] mod_pow(input logic [63:0] b, input logic [63:0] e,
                                          input logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    for (int i = 63; i >= 0; i--) begin
      acc = mod_mul(acc, acc, m);
      if (e[i]) begin
        acc = mod_mul(acc, b, m);
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] power_product_mod(input logic [tbme_pkg::IN_W-1:0] req,
                                                    input logic [63:0] m);
    logic [63:0] mask, b1, e1, b2, e2, prod, lone, shared_e, diff_e;
    mask = {64{1'b1}} >> (64 - OP_W);
    b1   = req[63:0] & mask;
    e1   = req[127:64] & mask;
    b2   = req[191:128] & mask;
    e2   = req[255:192] & mask;
    if (m == 64'd0) begin
      return 64'd0;
    end
    b1   = b1 % m;
    b2   = b2 % m;
    prod = mod_mul(b1, b2, m);
    if (e1 >= e2) begin
      shared_e = e2;
      diff_e   = e1 - e2;
      lone     = b1;
    end else begin
      shared_e = e1;
      diff_e   = e2 - e1;
      lone     = b2;
    end
    return mod_mul(mod_pow(prod, shared_e, m), mod_pow(lone, diff_e, m), m);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_exp();
    unique case ($urandom_range(7))
      0: return 64'd0;
      1: return {64{1'b1}};
      2: return 64'($urandom_range(15));
      default: return rnd64();
    endcase
  endfunction

  function automatic logic [63:0] pick_base(input logic [63:0] m);
    unique case ($urandom_range(5))
      0: return 64'd0;
      1: return {64{1'b1}};
      2: return m - 64'd1;
      default: return rnd64();
    endcase
  endfunction

  function automatic logic [63:0] pick_modulus();
    logic [63:0] r;
    unique case ($urandom_range(3))
      0: begin
        r = rnd64();
        return (r == 64'd0) ? 64'd1 : r;
      end
      1: return 64'($urandom_range(1, 65535));
      2: return {1'b1, rnd64() >> 1};
      default: return 64'($urandom_range(2, 255));
    endcase
  endfunction

  task automatic push_request(input logic [63:0] b1, input logic [63:0] e1,
                              input logic [63:0] b2, input logic [63:0] e2,
                              input logic hold);
    request_t r;
    r.data = {e2, b2, e1, b1};
    r.hold = hold;
    request_q.push_back(r);
  endtask

  // block is idle once nothing is queued, in flight or outstanding
  task automatic wait_idle();
    do @(posedge clk);
    while (request_q.size() != 0 || s_axis_tvalid || product_q.size() != 0);
  endtask

  task automatic write_modulus(input logic [63:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_wr_data    <= value;
    @(negedge clk);
    cfg_wr_en      <= 1'b0;
    modulus_shadow = value;
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(input int n, input int src_pct, input int snk_pct,
                              input logic force_hold);
    logic [63:0] e1, m;
    m = pick_modulus();
    write_modulus(m);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int k = 0; k < n; k++) begin
      e1 = pick_exp();
      push_request(pick_base(m), e1, pick_base(m),
                   ($urandom_range(5) == 0) ? e1 : pick_exp(),
                   (force_hold && k == 4) || $urandom_range(11) == 0);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (request_q.size() != 0 && !(request_q[0].hold && product_q.size() != 0) &&
          $urandom_range(99) >= src_idle_pct) begin
        s_axis_tdata  <= request_q[0].data;
        s_axis_tvalid <= 1'b1;
        void'(request_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= snk_idle_pct);
  end

  // monitor
  always @(posedge clk) begin : monitor_proc
    logic [63:0] want;
    in_fire <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      product_q.push_back(power_product_mod(s_axis_tdata, modulus_shadow));
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (product_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("unexpected result %h", m_axis_tdata);
        end
      end else begin
        want = product_q.pop_front();
        if (m_axis_tdata !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("result mismatch: expected %h got %h", want, m_axis_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("[two_base_modular_exponentiation_top] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // modulus left at its reset value of one: everything reduces to zero
    push_request(64'd5, 64'd3, 64'd7, 64'd2, 1'b0);
    push_request({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 64'd0, 1'b0);

    write_modulus({64{1'b1}});
    push_request(64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
    push_request({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 1'b0);
    push_request({64{1'b1}} - 64'd1, {64{1'b1}}, 64'd2, 64'd0, 1'b0);
    push_request(64'd3, 64'd5, 64'd7, 64'd9, 1'b0);
    push_request(64'd3, 64'd9, 64'd7, 64'd5, 1'b0);
    push_request(64'd3, 64'd7, 64'd5, 64'd7, 1'b0);
    push_request(64'hDEADBEEFCAFEF00D, 64'd0, 64'h0123456789ABCDEF, 64'd0, 1'b0);
    push_request(64'd0, 64'd4, 64'd11, 64'd0, 1'b0);
    push_request(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
                 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1'b0);

    // zero modulus
    write_modulus(64'd0);
    push_request(64'd5, 64'd3, 64'd7, 64'd2, 1'b0);
    push_request({64{1'b1}}, 64'd0, 64'd1, 64'd0, 1'b0);

    write_modulus(64'd2);
    push_request(64'd3, 64'd1, 64'd5, 64'd1, 1'b0);
    push_request(64'd4, 64'd0, 64'd6, 64'd0, 1'b0);

    write_modulus(64'h8000000000000000);
    push_request(64'h7FFFFFFFFFFFFFFF, 64'd3, {64{1'b1}}, 64'd2, 1'b0);
    push_request(64'h8000000000000000, 64'd1, 64'd2, 64'd62, 1'b0);

    write_modulus(64'd1000003);
    push_request(64'd2, 64'd1000002, 64'd3, 64'd1000001, 1'b0);
    push_request(64'd1000003, 64'd7, 64'd1000004, 64'd7, 1'b0);

    random_phase(14, 29, 88, 1'b1);
    random_phase(14, 29, 88, 1'b0);
    random_phase(14, 88, 29, 1'b0);
    random_phase(14, 88, 29, 1'b0);
    random_phase(14, 0, 0, 1'b0);
    random_phase(14, 0, 0, 1'b0);

    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_cnt == 0 && product_q.size() == 0) begin
      $display("[two_base_modular_exponentiation_top] OK");
    end else begin
      $display("[two_base_modular_exponentiation_top] ERROR");
    end
    $finish;
  end

endmodule
